[design/dfsbe_pkg.sv]
// Shared types and constants for the depth-first back-edge finder.
// Holds payload widths, opcodes, status codes, controller states and
// the command/status structs between controller and datapath. No dependencies.
package dfsbe_pkg;

   localparam int OP_W   = 2;
   localparam int VTX_W  = 8;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BEYOND = 2'd2;

   localparam logic [VTX_W-1:0] ROOT_VERTEX = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR,
      ST_ADD_CHK,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_RUN_HEAD,
      ST_RUN_ROOT,
      ST_TOP,
      ST_POP,
      ST_NB,
      ST_PUSH,
      ST_SCAN,
      ST_CMP,
      ST_RD_CHK,
      ST_RD_DATA,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              latch;
      logic              clr_graph;
      logic              add_rd;
      logic              add_wr;
      logic              run_start;
      logic              run_root;
      logic              fetch;
      logic              pop;
      logic              pop_load;
      logic              nb_step;
      logic              descend;
      logic              push;
      logic              scan_start;
      logic              scan_rd;
      logic              scan_next;
      logic              record;
      logic              read_rd;
      logic              res_set;
      logic              res_edge;
      logic [STAT_W-1:0] res_code;
      logic              rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic edge_full;
      logic range_ok;
      logic end_second;
      logic top_none;
      logic depth_one;
      logic nb_in;
      logic nb_vis;
      logic nb_par;
      logic scan_end;
      logic scan_hit;
      logic read_ok;
   } status_type;

endpackage

[design/dfsbe_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on dfsbe_pkg for payload widths.
interface dfsbe_req_if;
   logic                            valid;
   logic                            ready;
   logic [dfsbe_pkg::OP_W-1:0]      opcode;
   logic [dfsbe_pkg::VTX_W-1:0]     vertex_a;
   logic [dfsbe_pkg::VTX_W-1:0]     vertex_b;
   logic [dfsbe_pkg::IDX_W-1:0]     read_index;

   modport source (output valid, opcode, vertex_a, vertex_b, read_index, input ready);
   modport sink   (input valid, opcode, vertex_a, vertex_b, read_index, output ready);
endinterface

interface dfsbe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dfsbe_pkg::STAT_W-1:0]    status;
   logic [dfsbe_pkg::CNT_W-1:0]     back_edge_count;
   logic [dfsbe_pkg::VTX_W-1:0]     edge_first;
   logic [dfsbe_pkg::VTX_W-1:0]     edge_second;

   modport source (output valid, status, back_edge_count, edge_first, edge_second,
                   input ready);
   modport sink   (input valid, status, back_edge_count, edge_first, edge_second,
                   output ready);
endinterface

[design/dfsbe_ctrl.sv]
// Controller state machine: sequences edge loads, the stack-based search,
// back-edge dedup scans, reads and the response register handshake.
// Depends on dfsbe_pkg.
module dfsbe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [dfsbe_pkg::OP_W-1:0] req_opcode,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dfsbe_pkg::cmd_type      cmd,
   input  dfsbe_pkg::status_type   sts
);
   import dfsbe_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_opcode))
                  OP_CLEAR: state_in = ST_CLR;
                  OP_ADD:   state_in = ST_ADD_CHK;
                  OP_RUN:   state_in = ST_RUN_HEAD;
                  OP_READ:  state_in = ST_RD_CHK;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR:      state_in = ST_RESP;
         ST_ADD_CHK:  state_in = (sts.edge_full || !sts.range_ok) ? ST_RESP : ST_ADD_RD;
         ST_ADD_RD:   state_in = ST_ADD_WR;
         ST_ADD_WR:   state_in = sts.end_second ? ST_RESP : ST_ADD_RD;
         ST_RUN_HEAD: state_in = ST_RUN_ROOT;
         ST_RUN_ROOT: state_in = ST_TOP;
         ST_TOP: begin
            if (sts.top_none) state_in = sts.depth_one ? ST_RESP : ST_POP;
            else              state_in = ST_NB;
         end
         ST_POP:      state_in = ST_TOP;
         ST_NB: begin
            if (!sts.nb_in)       state_in = ST_TOP;
            else if (!sts.nb_vis) state_in = ST_PUSH;
            else if (!sts.nb_par) state_in = ST_SCAN;
            else                  state_in = ST_TOP;
         end
         ST_PUSH:     state_in = ST_TOP;
         ST_SCAN:     state_in = sts.scan_end ? ST_TOP : ST_CMP;
         ST_CMP:      state_in = sts.scan_hit ? ST_TOP : ST_SCAN;
         ST_RD_CHK:   state_in = sts.read_ok ? ST_RD_DATA : ST_RESP;
         ST_RD_DATA:  state_in = ST_RESP;
         ST_RESP:     state_in = rsp_free ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.res_code = STATUS_OK;
      case (state_ff)
         ST_IDLE:     cmd.latch = req_valid;
         ST_CLR: begin
            cmd.clr_graph = 1'b1;
            cmd.res_set   = 1'b1;
         end
         ST_ADD_CHK: begin
            cmd.res_set  = sts.edge_full || !sts.range_ok;
            cmd.res_code = sts.edge_full ? STATUS_FULL : STATUS_OK;
         end
         ST_ADD_RD:   cmd.add_rd = 1'b1;
         ST_ADD_WR: begin
            cmd.add_wr  = 1'b1;
            cmd.res_set = sts.end_second;
         end
         ST_RUN_HEAD: cmd.run_start = 1'b1;
         ST_RUN_ROOT: cmd.run_root = 1'b1;
         ST_TOP: begin
            cmd.pop     = sts.top_none;
            cmd.res_set = sts.top_none && sts.depth_one;
            cmd.fetch   = !sts.top_none;
         end
         ST_POP:      cmd.pop_load = 1'b1;
         ST_NB: begin
            cmd.nb_step    = 1'b1;
            cmd.descend    = sts.nb_in && !sts.nb_vis;
            cmd.scan_start = sts.nb_in && sts.nb_vis && !sts.nb_par;
         end
         ST_PUSH:     cmd.push = 1'b1;
         ST_SCAN: begin
            cmd.record  = sts.scan_end;
            cmd.scan_rd = !sts.scan_end;
         end
         ST_CMP:      cmd.scan_next = !sts.scan_hit;
         ST_RD_CHK: begin
            cmd.read_rd  = sts.read_ok;
            cmd.res_set  = !sts.read_ok;
            cmd.res_code = STATUS_BEYOND;
         end
         ST_RD_DATA: begin
            cmd.res_set  = 1'b1;
            cmd.res_edge = 1'b1;
         end
         ST_RESP:     cmd.rsp_load = rsp_free;
         default:     cmd = '0;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/dfsbe_dp.sv]
// Datapath: adjacency memories, list heads/tails, visited marks, the
// search stack with a cached top entry, and the back-edge store.
// Depends on dfsbe_pkg; driven by dfsbe_ctrl commands.
module dfsbe_dp #(
   parameter int MAX_VERTICES   = 256,
   parameter int MAX_EDGES      = 1024,
   parameter int MAX_BACK_EDGES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [dfsbe_pkg::VTX_W-1:0]   req_vertex_a,
   input  logic [dfsbe_pkg::VTX_W-1:0]   req_vertex_b,
   input  logic [dfsbe_pkg::IDX_W-1:0]   req_read_index,
   input  dfsbe_pkg::cmd_type            cmd,
   output dfsbe_pkg::status_type         sts,
   output logic [dfsbe_pkg::STAT_W-1:0]  rsp_status,
   output logic [dfsbe_pkg::CNT_W-1:0]   rsp_back_edge_count,
   output logic [dfsbe_pkg::VTX_W-1:0]   rsp_edge_first,
   output logic [dfsbe_pkg::VTX_W-1:0]   rsp_edge_second
);
   import dfsbe_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int SLOTS = 2 * MAX_EDGES;
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int ETW   = $clog2(MAX_EDGES + 1);
   localparam int FW    = (MAX_BACK_EDGES > 1) ? $clog2(MAX_BACK_EDGES) : 1;
   localparam int TW    = $clog2(MAX_BACK_EDGES + 1);
   localparam int DW    = $clog2(MAX_VERTICES + 1);
   localparam int EW    = 2 * VTX_W + CW;
   localparam logic [CW-1:0] NONE = CW'(SLOTS);

   // memories
   logic [VTX_W-1:0]   nb_mem   [SLOTS];
   logic [CW-1:0]      link_mem [SLOTS];
   logic [SW-1:0]      head_mem [MAX_VERTICES];
   logic [SW-1:0]      tail_mem [MAX_VERTICES];
   logic [EW-1:0]      stk_mem  [MAX_VERTICES];
   logic [2*VTX_W-1:0] fnd_mem  [MAX_BACK_EDGES];

   // latched request
   logic [VTX_W-1:0] a_ff, b_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             end_ff;

   // control state
   logic [MAX_VERTICES-1:0] head_valid_ff, visited_ff;
   logic [ETW-1:0]          edge_total_ff;
   logic [TW-1:0]           found_total_ff, scan_i_ff;
   logic [DW-1:0]           depth_ff;

   // memory read registers
   logic [VTX_W-1:0]   nb_rd;
   logic [CW-1:0]      link_rd;
   logic [SW-1:0]      tail_rd, head_rd;
   logic               head_ok_ff;
   logic [EW-1:0]      stk_rd;
   logic [2*VTX_W-1:0] fnd_rd;

   // stack top and search scratch
   logic [VTX_W-1:0] top_v_ff, top_p_ff, hold_ff;
   logic [CW-1:0]    top_c_ff;

   // result registers
   logic [STAT_W-1:0] res_status_ff, out_status_ff;
   logic [VTX_W-1:0]  res_first_ff, res_second_ff, out_first_ff, out_second_ff;
   logic [CNT_W-1:0]  out_count_ff;

   logic [VTX_W-1:0] cur_v, cur_n;
   logic [SW-1:0]    slot;
   logic [CW-1:0]    head_sel;
   logic             found_room;

   assign cur_v      = end_ff ? b_ff : a_ff;
   assign cur_n      = end_ff ? a_ff : b_ff;
   assign slot       = SW'({edge_total_ff, end_ff});
   assign head_sel   = head_ok_ff ? CW'(head_rd) : NONE;
   assign found_room = 32'(found_total_ff) < MAX_BACK_EDGES;

   // status flags
   always_comb begin
      sts.edge_full  = edge_total_ff == ETW'(MAX_EDGES);
      sts.range_ok   = (32'(a_ff) < MAX_VERTICES) && (32'(b_ff) < MAX_VERTICES);
      sts.end_second = end_ff;
      sts.top_none   = top_c_ff == NONE;
      sts.depth_one  = depth_ff == DW'(1);
      sts.nb_in      = 32'(nb_rd) < MAX_VERTICES;
      sts.nb_vis     = visited_ff[VW'(nb_rd)];
      sts.nb_par     = nb_rd == top_p_ff;
      sts.scan_end   = scan_i_ff == found_total_ff;
      sts.scan_hit   = (fnd_rd == {hold_ff, top_v_ff}) || (fnd_rd == {top_v_ff, hold_ff});
      sts.read_ok    = 32'(idx_ff) < 32'(found_total_ff);
   end

   // adjacency slots: new slot on load, tail link patch, cursor fetch
   always_ff @(posedge clock) begin
      if (cmd.add_rd) begin
         nb_mem[slot]   <= cur_n;
         link_mem[slot] <= NONE;
      end
      if (cmd.add_wr && head_valid_ff[VW'(cur_v)]) link_mem[tail_rd] <= CW'(slot);
      if (cmd.fetch) begin
         nb_rd   <= nb_mem[top_c_ff[SW-1:0]];
         link_rd <= link_mem[top_c_ff[SW-1:0]];
      end
   end

   // list heads and tails
   always_ff @(posedge clock) begin
      if (cmd.add_rd) tail_rd <= tail_mem[VW'(cur_v)];
      if (cmd.add_wr) begin
         tail_mem[VW'(cur_v)] <= slot;
         if (!head_valid_ff[VW'(cur_v)]) head_mem[VW'(cur_v)] <= slot;
      end
      if (cmd.run_start) begin
         head_rd    <= head_mem[VW'(ROOT_VERTEX)];
         head_ok_ff <= head_valid_ff[VW'(ROOT_VERTEX)];
      end else if (cmd.descend) begin
         head_rd    <= head_mem[VW'(nb_rd)];
         head_ok_ff <= head_valid_ff[VW'(nb_rd)];
      end
   end

   // stack memory holds every entry below the cached top
   always_ff @(posedge clock) begin
      if (cmd.push) stk_mem[VW'(depth_ff - DW'(1))] <= {top_v_ff, top_p_ff, top_c_ff};
      if (cmd.pop)  stk_rd <= stk_mem[VW'(depth_ff - DW'(2))];
   end

   // back-edge store
   always_ff @(posedge clock) begin
      if (cmd.record && found_room) fnd_mem[FW'(found_total_ff)] <= {hold_ff, top_v_ff};
      if (cmd.scan_rd)      fnd_rd <= fnd_mem[FW'(scan_i_ff)];
      else if (cmd.read_rd) fnd_rd <= fnd_mem[FW'(idx_ff)];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff  <= '0;
         visited_ff     <= '0;
         edge_total_ff  <= '0;
         found_total_ff <= '0;
         depth_ff       <= '0;
      end else begin
         if (cmd.clr_graph) begin
            head_valid_ff <= '0;
            edge_total_ff <= '0;
         end
         if (cmd.add_wr) begin
            head_valid_ff[VW'(cur_v)] <= 1'b1;
            if (end_ff) edge_total_ff <= edge_total_ff + ETW'(1);
         end
         // new search: only the root is marked
         if (cmd.run_start) begin
            visited_ff     <= MAX_VERTICES'(1) << ROOT_VERTEX;
            found_total_ff <= '0;
         end
         if (cmd.descend) visited_ff[VW'(nb_rd)] <= 1'b1;
         if (cmd.record && found_room) found_total_ff <= found_total_ff + TW'(1);
         if (cmd.run_root) depth_ff <= DW'(1);
         if (cmd.push)     depth_ff <= depth_ff + DW'(1);
         if (cmd.pop)      depth_ff <= depth_ff - DW'(1);
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         a_ff   <= req_vertex_a;
         b_ff   <= req_vertex_b;
         idx_ff <= req_read_index;
         end_ff <= 1'b0;
      end
      if (cmd.add_wr) end_ff <= ~end_ff;
      if (cmd.descend || cmd.scan_start) hold_ff <= nb_rd;
      if (cmd.scan_start) scan_i_ff <= '0;
      if (cmd.scan_next)  scan_i_ff <= scan_i_ff + TW'(1);
      if (cmd.run_root) begin
         top_v_ff <= ROOT_VERTEX;
         top_p_ff <= ROOT_VERTEX;
         top_c_ff <= head_sel;
      end
      if (cmd.nb_step) top_c_ff <= link_rd;
      if (cmd.push) begin
         top_v_ff <= hold_ff;
         top_p_ff <= top_v_ff;
         top_c_ff <= head_sel;
      end
      if (cmd.pop_load) {top_v_ff, top_p_ff, top_c_ff} <= stk_rd;
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         res_first_ff  <= cmd.res_edge ? fnd_rd[2*VTX_W-1:VTX_W] : '0;
         res_second_ff <= cmd.res_edge ? fnd_rd[VTX_W-1:0] : '0;
      end
      if (cmd.rsp_load) begin
         out_status_ff <= res_status_ff;
         out_count_ff  <= CNT_W'(found_total_ff);
         out_first_ff  <= res_first_ff;
         out_second_ff <= res_second_ff;
      end
   end

   assign rsp_status          = out_status_ff;
   assign rsp_back_edge_count = out_count_ff;
   assign rsp_edge_first      = out_first_ff;
   assign rsp_edge_second     = out_second_ff;

endmodule

[design/dfs_back_edge_finder.sv]
// Top level of the depth-first back-edge finder.
// Depends on dfsbe_pkg, dfsbe_if, dfsbe_ctrl and dfsbe_dp.
//
// Usage: one request beat on req carries opcode, vertex_a, vertex_b and
// read_index; exactly one response beat on rsp follows with status,
// back_edge_count, edge_first and edge_second.
//   clear graph : clears the graph, then loads the response register.
//   add edge    : one check, then two list appends (one tail-memory read
//                 and one link write per append).
//   read        : one range check, then one registered back-edge store read.
//   run search  : root set-up, then a fetch and a step per adjacency slot
//                 walked, a push per vertex descended to and a pop per vertex
//                 finished; at each non-tree visit the dedup scan compares
//                 the stored back edges one entry at a time before recording
//                 a new one.
// One request is in work at a time; req.ready is high while idle.
// A finished response waits in the output register; if rsp.ready is low
// the block holds it, and the next response waits until it has been taken.
// Reset (synchronous, active high) empties the graph, zeroes the back-edge
// count and visited marks; memories need no clearing pass.
module dfs_back_edge_finder #(
   parameter int MAX_VERTICES   = 256,
   parameter int MAX_EDGES      = 1024,
   parameter int MAX_BACK_EDGES = 1024
) (
   input logic        clock,
   input logic        reset,
   dfsbe_req_if.sink  req,
   dfsbe_rsp_if.source rsp
);
   import dfsbe_pkg::*;

   cmd_type    cmd;
   status_type sts;

   dfsbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_opcode (req.opcode),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   dfsbe_dp #(
      .MAX_VERTICES   (MAX_VERTICES),
      .MAX_EDGES      (MAX_EDGES),
      .MAX_BACK_EDGES (MAX_BACK_EDGES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_vertex_a        (req.vertex_a),
      .req_vertex_b        (req.vertex_b),
      .req_read_index      (req.read_index),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_status          (rsp.status),
      .rsp_back_edge_count (rsp.back_edge_count),
      .rsp_edge_first      (rsp.edge_first),
      .rsp_edge_second     (rsp.edge_second)
   );

endmodule

[bench/tb_dfs_back_edge_finder.sv]
// Testbench for dfs_back_edge_finder: directed and random command streams,
// an in-bench graph/DFS predictor and a beat-by-beat response checker.
// Depends on dfsbe_pkg, dfsbe_if and the design top level.
module tb_dfs_back_edge_finder;
   timeunit 1ns;
   timeprecision 1ps;
   import dfsbe_pkg::*;

   localparam int NUM_VTX   = 256;
   localparam int NUM_EDGES = 1024;
   localparam int NUM_BACK  = 1024;
   localparam int SLOTS     = 2 * NUM_EDGES;
   localparam int NO_SLOT   = SLOTS;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count;
      logic [VTX_W-1:0]  first;
      logic [VTX_W-1:0]  second;
   } rsp_beat_t;

   logic clock;
   logic reset;

   dfsbe_req_if req ();
   dfsbe_rsp_if rsp ();

   dfs_back_edge_finder uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // graph mirror
   int        adj_nbr [SLOTS];
   int        adj_next[SLOTS];
   int        head    [NUM_VTX];
   int        tail    [NUM_VTX];
   bit        seen    [NUM_VTX];
   int        stk_v   [NUM_VTX];
   int        stk_par [NUM_VTX];
   int        stk_cur [NUM_VTX];
   int        stk_depth;
   int        edge_cnt;
   int        back_a  [NUM_BACK];
   int        back_b  [NUM_BACK];
   int        back_cnt;

   rsp_beat_t pending_rsp[$];
   int        errors;
   int        items_sent;
   int        idle_pct;
   int        stall_pct;

   always #4 clock = ~clock;

   function automatic void clear_graph();
      for (int i = 0; i < NUM_VTX; i++) begin
         head[i] = NO_SLOT;
         tail[i] = 0;
      end
      edge_cnt = 0;
   endfunction

   function automatic void append_slot(int v, int n, int slot);
      adj_nbr[slot]  = n;
      adj_next[slot] = NO_SLOT;
      if (head[v] == NO_SLOT) head[v] = slot;
      else adj_next[tail[v]] = slot;
      tail[v] = slot;
   endfunction

   function automatic void push_vtx(int v, int par);
      if (stk_depth < NUM_VTX) begin
         seen[v]            = 1'b1;
         stk_v[stk_depth]   = v;
         stk_par[stk_depth] = par;
         stk_cur[stk_depth] = head[v];
         stk_depth++;
      end
   endfunction

   function automatic void note_back_edge(int x, int y);
      for (int i = 0; i < back_cnt; i++)
         if ((back_a[i] == x && back_b[i] == y) || (back_a[i] == y && back_b[i] == x))
            return;
      if (back_cnt < NUM_BACK) begin
         back_a[back_cnt] = x;
         back_b[back_cnt] = y;
         back_cnt++;
      end
   endfunction

   // iterative DFS from the root, collecting distinct non-tree edges
   function automatic void search_graph();
      int top;
      int cur;
      int v;
      int n;
      for (int i = 0; i < NUM_VTX; i++) seen[i] = 1'b0;
      back_cnt  = 0;
      stk_depth = 0;
      push_vtx(int'(ROOT_VERTEX), int'(ROOT_VERTEX));
      while (stk_depth > 0) begin
         top = stk_depth - 1;
         cur = stk_cur[top];
         if (cur >= SLOTS) begin
            stk_depth--;
            continue;
         end
         v            = stk_v[top];
         n            = adj_nbr[cur];
         stk_cur[top] = adj_next[cur];
         if (!seen[n]) push_vtx(n, v);
         else if (n != stk_par[top]) note_back_edge(n, v);
      end
   endfunction

   function automatic rsp_beat_t predict_rsp(op_type op, int a, int b, int idx);
      rsp_beat_t r;
      r.status = STATUS_OK;
      r.first  = '0;
      r.second = '0;
      case (op)
         OP_CLEAR: clear_graph();
         OP_ADD: begin
            if (edge_cnt >= NUM_EDGES) r.status = STATUS_FULL;
            else begin
               append_slot(a, b, 2 * edge_cnt);
               append_slot(b, a, 2 * edge_cnt + 1);
               edge_cnt++;
            end
         end
         OP_RUN: search_graph();
         default: begin
            if (idx < back_cnt) begin
               r.first  = VTX_W'(back_a[idx]);
               r.second = VTX_W'(back_b[idx]);
            end else r.status = STATUS_BEYOND;
         end
      endcase
      r.count = CNT_W'(back_cnt);
      return r;
   endfunction

   // one request beat; prediction is taken at the accepting edge
   task automatic send_cmd(op_type op, int a, int b, int idx);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req.opcode     <= op;
      req.vertex_a   <= VTX_W'(a);
      req.vertex_b   <= VTX_W'(b);
      req.read_index <= IDX_W'(idx);
      req.valid      <= 1'b1;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(predict_rsp(op, a, b, idx));
      items_sent++;
   endtask

   task automatic send_rand(op_type op);
      send_cmd(op, $urandom_range(255), $urandom_range(255), $urandom_range(1023));
   endtask

   // hold off the sender until every response is back
   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // response stall pattern
   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= stall_pct);

   // response checker
   always @(posedge clock) begin
      rsp_beat_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with nothing expected", $realtime);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp.status !== e.status) begin
               $display("%0t: status exp %0d act %0d", $realtime, e.status, rsp.status);
               errors++;
            end
            if (rsp.back_edge_count !== e.count) begin
               $display("%0t: back_edge_count exp %0d act %0d", $realtime, e.count,
                        rsp.back_edge_count);
               errors++;
            end
            if (rsp.edge_first !== e.first) begin
               $display("%0t: edge_first exp %0d act %0d", $realtime, e.first,
                        rsp.edge_first);
               errors++;
            end
            if (rsp.edge_second !== e.second) begin
               $display("%0t: edge_second exp %0d act %0d", $realtime, e.second,
                        rsp.edge_second);
               errors++;
            end
         end
      end
   end

   // extremes, self loop, parallel edges, root, reads past count, clear keeps count
   task automatic test_directed();
      send_cmd(OP_READ, 0, 0, 0);
      send_cmd(OP_RUN, 0, 0, 0);
      send_cmd(OP_ADD, 1, 1, 0);
      send_cmd(OP_ADD, 1, 2, 0);
      send_cmd(OP_ADD, 2, 1, 0);
      send_cmd(OP_ADD, 2, 3, 0);
      send_cmd(OP_ADD, 3, 1, 0);
      send_cmd(OP_ADD, 255, 0, 1023);
      send_cmd(OP_ADD, 0, 255, 0);
      send_cmd(OP_ADD, 3, 255, 0);
      send_cmd(OP_ADD, 0, 1, 0);
      send_cmd(OP_ADD, 7, 9, 0);
      send_cmd(OP_RUN, 255, 255, 1023);
      for (int i = 0; i < 5; i++) send_cmd(OP_READ, 0, 0, i);
      send_cmd(OP_READ, 255, 255, 1023);
      send_cmd(OP_CLEAR, 255, 255, 1023);
      send_cmd(OP_READ, 0, 0, 0);
      send_cmd(OP_RUN, 0, 0, 0);
      send_cmd(OP_READ, 0, 0, 0);
   endtask

   // dense multigraph on a few vertices, then search and read back
   task automatic test_dense_graph();
      send_cmd(OP_CLEAR, 0, 0, 0);
      for (int i = 0; i < 100; i++)
         send_cmd(OP_ADD, $urandom_range(5), $urandom_range(5), $urandom_range(1023));
      send_rand(OP_ADD);
      send_rand(OP_ADD);
      send_rand(OP_RUN);
      for (int i = 0; i < 4; i++) send_cmd(OP_READ, 0, 0, i);
      send_rand(OP_CLEAR);
   endtask

   // build graph, search, read back; with some stray commands mixed in
   task automatic test_random(int n_items, int idle, int stall, bit pause);
      int stop_at;
      int vmax;
      int k;
      int a;
      stop_at   = items_sent + n_items;
      idle_pct  = idle;
      stall_pct = stall;
      while (items_sent < stop_at) begin
         if ($urandom_range(3) != 0 || edge_cnt > 900) send_rand(OP_CLEAR);
         case ($urandom_range(2))
            0: vmax = 7;
            1: vmax = 31;
            default: vmax = 255;
         endcase
         k = $urandom_range(1, 30);
         for (int i = 0; i < k; i++) begin
            a = ($urandom_range(2) == 0) ? 1 : $urandom_range(vmax);
            send_cmd(OP_ADD, a, $urandom_range(vmax), $urandom_range(1023));
            if ($urandom_range(19) == 0) send_rand(op_type'($urandom_range(3)));
         end
         send_rand(OP_RUN);
         if (pause && $urandom_range(3) == 0) drain();
         k = $urandom_range(1, 8);
         for (int i = 0; i < k; i++)
            send_cmd(OP_READ, $urandom_range(255), $urandom_range(255),
                     ($urandom_range(4) == 0) ? $urandom_range(1023)
                                              : $urandom_range(back_cnt + 1));
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.opcode     = OP_CLEAR;
      req.vertex_a   = '0;
      req.vertex_b   = '0;
      req.read_index = '0;
      rsp.ready      = 1'b0;
      errors         = 0;
      items_sent     = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      back_cnt       = 0;
      stk_depth      = 0;
      for (int i = 0; i < NUM_VTX; i++) seen[i] = 1'b0;
      clear_graph();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_dense_graph();
      test_random(140, 0, 0, 1'b0);
      test_random(140, 64, 0, 1'b1);
      test_random(140, 0, 64, 1'b0);
      test_random(140, 11, 11, 1'b1);

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
